[hw/rtl/cdd_pkg.sv]
package cdd_pkg;

  // Field widths
  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 14;
  localparam int unsigned OrdW  = 22;
  localparam int unsigned ProdW = 27;   // year times reciprocal of 100
  localparam int unsigned QuotW = 8;    // year / 100 stays below 164
  localparam int unsigned YdayW = 9;    // day of year, up to 366

  // Year limits
  localparam logic [YearW-1:0] YearCap       = 14'd9999;
  localparam logic [YearW-1:0] LatestYearRst = 14'd2023;

  // floor(x / 100) == (x * Recip100) >> Recip100Sh for every 14-bit x
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int unsigned Recip100Sh = 19;

  localparam logic [MonW-1:0] MonJan = 4'd1;
  localparam logic [MonW-1:0] MonFeb = 4'd2;
  localparam logic [MonW-1:0] MonDec = 4'd12;
  localparam logic [DayW-1:0] LeapDay = 5'd29;

  // Stage load enables of the date pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } cdd_stage_en_t;

  // Length of a month in a common year, 0 for codes that are no month
  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year
  function automatic logic [YdayW-1:0] days_before(input logic [MonW-1:0] m);
    logic [YdayW-1:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

[hw/rtl/calendar_date_difference.sv]
// Days between two Gregorian dates.
// Input stream s_axis: one transaction carries both dates. Output stream
// m_axis: one transaction per input transaction, in order; tuser flags
// that both dates were valid, tdata holds the absolute day count (zero
// when tuser is low). A date is valid for year 1 up to the latest year
// (capped at 9999), month 1..12 and a day within that month's length.
// cfg_we_i/cfg_wdata_i write the latest year; write it only
// while no transaction is in flight.
// The pipeline has four register stages in all: three per date (range
// checks and reciprocal products, leap rule and partial counts, ordinal
// sum) and a difference stage that is also the output register.
// Throughput is one transaction per cycle while the receiver does not
// stall.
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so a stalled receiver fills empty stages before
// s_axis_tready drops; nothing is lost or repeated.
// Reset clears the valid bits and sets the latest year to 2023.
module calendar_date_difference import cdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,    // latest_year
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_day[4:0], first_month[8:5], first_year[22:9], second_day[27:23],
  // second_month[31:28], second_year[45:32], zero[47:46]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // day_difference[21:0], zero[23:22]
  output logic        m_axis_tuser    // dates_valid
);

  // Latest year, capped on write
  logic [YearW-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LatestYearRst;
    end else if (cfg_we_i) begin
      lim_q <= (cfg_wdata_i > YearCap) ? YearCap : cfg_wdata_i;
    end
  end

  // Stage valid bits and load enables
  logic [3:0]    vld_q;
  logic [3:0]    rdy;
  cdd_stage_en_t en;

  always_comb begin
    rdy[3] = !vld_q[3] || m_axis_tready;
    rdy[2] = !vld_q[2] || rdy[3];
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
    en.s1  = rdy[0];
    en.s2  = rdy[1];
    en.s3  = rdy[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
    end
  end

  // Both dates in parallel
  logic            ok_a, ok_b;
  logic [OrdW-1:0] ord_a, ord_b;

  cdd_date_ord u_first (
    .clk_i   (clk_i),
    .en_i    (en),
    .lim_i   (lim_q),
    .day_i   (s_axis_tdata[4:0]),
    .month_i (s_axis_tdata[8:5]),
    .year_i  (s_axis_tdata[22:9]),
    .ok_o    (ok_a),
    .ord_o   (ord_a)
  );

  cdd_date_ord u_second (
    .clk_i   (clk_i),
    .en_i    (en),
    .lim_i   (lim_q),
    .day_i   (s_axis_tdata[27:23]),
    .month_i (s_axis_tdata[31:28]),
    .year_i  (s_axis_tdata[45:32]),
    .ok_o    (ok_b),
    .ord_o   (ord_b)
  );

  // Stage 4: absolute difference, forced to zero for invalid dates
  logic            ok_d, ok_q;
  logic [OrdW-1:0] diff_d, diff_q;

  always_comb begin
    ok_d = ok_a && ok_b;
    if (!ok_d) begin
      diff_d = '0;
    end else if (ord_a > ord_b) begin
      diff_d = ord_a - ord_b;
    end else begin
      diff_d = ord_b - ord_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      ok_q   <= ok_d;
      diff_q <= diff_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[3];
  assign m_axis_tdata  = {2'b00, diff_q};
  assign m_axis_tuser  = ok_q;

endmodule

[hw/rtl/cdd_date_ord.sv]
// Three-stage pipeline: checks one date and turns it into a day ordinal
// counted from 1 January of year 1.
module cdd_date_ord import cdd_pkg::*; (
  input  logic             clk_i,
  input  cdd_stage_en_t    en_i,
  input  logic [YearW-1:0] lim_i,
  input  logic [DayW-1:0]  day_i,
  input  logic [MonW-1:0]  month_i,
  input  logic [YearW-1:0] year_i,
  output logic             ok_o,
  output logic [OrdW-1:0]  ord_o
);

  // Stage 1: range checks, reciprocal products for the divisions by 100
  logic [YearW-1:0] p_d, p_q, y_q;
  logic [ProdW-1:0] prod_p_d, prod_p_q, prod_y_d, prod_y_q;
  logic             base_ok_d, base_ok_q, day_ok_d, day_ok_q, feb29_d, feb29_q;
  logic [DayW-1:0]  day_q;
  logic [MonW-1:0]  mon_q;

  always_comb begin
    p_d       = year_i - YearW'(1);
    prod_p_d  = ProdW'(p_d) * ProdW'(Recip100);
    prod_y_d  = ProdW'(year_i) * ProdW'(Recip100);
    base_ok_d = (year_i != '0) && (year_i <= lim_i) &&
                (month_i >= MonJan) && (month_i <= MonDec);
    day_ok_d  = (day_i != '0) && (day_i <= month_len(month_i));
    feb29_d   = (month_i == MonFeb) && (day_i == LeapDay);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      p_q       <= p_d;
      y_q       <= year_i;
      prod_p_q  <= prod_p_d;
      prod_y_q  <= prod_y_d;
      base_ok_q <= base_ok_d;
      day_ok_q  <= day_ok_d;
      feb29_q   <= feb29_d;
      day_q     <= day_i;
      mon_q     <= month_i;
    end
  end

  // Stage 2: leap rule, final check, year and in-year day counts
  logic [QuotW-1:0] qy, qp;
  logic [14:0]      qy100;
  logic             leap;
  logic             ok2_d, ok2_q;
  logic [YdayW-1:0] yday_d, yday_q;
  logic [OrdW-1:0]  ydays_d, ydays_q;
  logic [QuotW-1:0] corr_d, corr_q;

  always_comb begin
    qy      = prod_y_q[Recip100Sh +: QuotW];
    qp      = prod_p_q[Recip100Sh +: QuotW];
    qy100   = 15'(qy) * 15'd100;
    // divisible by 4, and not a century unless divisible by 400
    leap    = (y_q[1:0] == 2'b00) && ((15'(y_q) != qy100) || (qy[1:0] == 2'b00));
    ok2_d   = base_ok_q && (day_ok_q || (feb29_q && leap));
    yday_d  = days_before(mon_q) + YdayW'(day_q) +
              YdayW'((mon_q > MonFeb) && leap);
    ydays_d = OrdW'(p_q) * OrdW'(365) + OrdW'(p_q[YearW-1:2]);
    corr_d  = qp - (qp >> 2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      ok2_q   <= ok2_d;
      yday_q  <= yday_d;
      ydays_q <= ydays_d;
      corr_q  <= corr_d;
    end
  end

  // Stage 3: ordinal sum
  logic            ok3_q;
  logic [OrdW-1:0] ord_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      ok3_q <= ok2_q;
      ord_q <= ydays_q - OrdW'(corr_q) + OrdW'(yday_q);
    end
  end

  assign ok_o  = ok3_q;
  assign ord_o = ord_q;

endmodule

[tb/calendar_date_difference_test.sv]
`timescale 1ns / 1ps

module calendar_date_difference_test;
  import cdd_pkg::*;

  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned RandomPerPhase = 90;
  localparam int unsigned HoldCycles     = 60;
  localparam int unsigned HoldItems      = 30;

  // One calendar date, day in the lowest bits
  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
  } date_t;

  // Input transaction payload, first date in the lowest bits
  typedef struct packed {
    date_t second;
    date_t first;
  } date_pair_t;

  // Result transaction: validity flag and day span
  typedef struct packed {
    logic            valid;
    logic [OrdW-1:0] days;
  } span_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [13:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [YearW-1:0] latest_year_reg = LatestYearRst;
  span_t            pending_spans[$];
  int unsigned      error_count    = 0;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  logic             recv_hold      = 1'b0;

  calendar_date_difference uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------

  // Gregorian rule: every 4th year, centuries only when divisible by 400
  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Only called for months 1..12
  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      4, 6, 9, 11: return 30;
      MonFeb:      return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // Register value with the 9999 cap applied
  function automatic int unsigned year_limit();
    return (latest_year_reg > YearCap) ? YearCap : latest_year_reg;
  endfunction

  function automatic bit date_legal(input date_t dt);
    if (dt.year < 1 || dt.year > year_limit()) return 1'b0;
    if (dt.month < MonJan || dt.month > MonDec) return 1'b0;
    return (dt.day >= 1) && (dt.day <= month_length(dt.month, dt.year));
  endfunction

  // Days counted from 1 January of year 1, which is day 1
  function automatic int unsigned day_ordinal(input date_t dt);
    int unsigned p;
    int unsigned n;
    p = dt.year - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned mo = 1; mo < dt.month; mo++) n += month_length(mo, dt.year);
    return n + dt.day;
  endfunction

  function automatic span_t predict_span(input date_pair_t p);
    span_t       s;
    int unsigned a;
    int unsigned b;
    s = '0;
    if (date_legal(p.first) && date_legal(p.second)) begin
      a = day_ordinal(p.first);
      b = day_ordinal(p.second);
      s.valid = 1'b1;
      s.days  = OrdW'((a > b) ? a - b : b - a);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Random dates: mostly legal, some raw noise, February of centuries,
  // and legal dates with one field pushed out of range
  // ---------------------------------------------------------------------
  function automatic date_t random_date();
    date_t       dt;
    logic [31:0] r;
    int unsigned lim;
    int unsigned pick;
    lim  = year_limit();
    pick = $urandom_range(99);
    if (pick < 20 || lim == 0) begin
      r  = $urandom;
      dt = r[$bits(date_t)-1:0];
    end else begin
      dt.year = YearW'($urandom_range(lim, 1));
      if (pick < 30 && lim >= 100) begin
        dt.year  = YearW'(100 * $urandom_range(lim / 100, 1));
        dt.month = MonFeb;
        dt.day   = DayW'($urandom_range(29, 28));
      end else begin
        dt.month = MonW'($urandom_range(12, 1));
        dt.day   = DayW'($urandom_range(month_length(dt.month, dt.year), 1));
      end
      if (pick >= 90) begin
        case ($urandom_range(2))
          0: dt.day = $urandom_range(1) ? '0 :
                      DayW'(month_length(dt.month, dt.year) + 1);
          1: dt.month = $urandom_range(1) ? '0 : MonW'($urandom_range(15, 13));
          default: dt.year = $urandom_range(1) ? '0 : YearW'(lim + 1);
        endcase
      end
    end
    return dt;
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    p.first  = random_date();
    p.second = ($urandom_range(19) == 0) ? p.first : random_date();
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------

  // Offer one transaction; tvalid stays high afterwards unless the next
  // call idles first
  task automatic send_pair(input date_pair_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, p};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_spans.push_back(predict_span(p));
  endtask

  task automatic send_dates(input int unsigned d1, m1, y1, d2, m2, y2);
    date_pair_t p;
    p.first.day    = DayW'(d1);
    p.first.month  = MonW'(m1);
    p.first.year   = YearW'(y1);
    p.second.day   = DayW'(d2);
    p.second.month = MonW'(m2);
    p.second.year  = YearW'(y2);
    send_pair(p);
  endtask

  // Register write once the pipeline has drained
  task automatic set_latest_year(input logic [YearW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    latest_year_reg = value;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset limit of 2023: leap rule, range edges, span direction
  task automatic test_directed_dates();
    send_dates(1, 1, 1, 1, 1, 1);
    send_dates(31, 12, 2023, 1, 1, 1);
    send_dates(1, 1, 2023, 31, 12, 2022);
    send_dates(31, 12, 2022, 1, 1, 2023);
    send_dates(29, 2, 2000, 1, 3, 2000);
    send_dates(29, 2, 1900, 1, 3, 1900);
    send_dates(28, 2, 1900, 1, 3, 1900);
    send_dates(29, 2, 2020, 28, 2, 2021);
    send_dates(29, 2, 2023, 1, 1, 2023);
    send_dates(30, 4, 2023, 31, 4, 2023);
    send_dates(0, 1, 2000, 1, 1, 2000);
    send_dates(31, 15, 16383, 31, 15, 16383);
    send_dates(1, 0, 2000, 1, 13, 2000);
    send_dates(0, 0, 0, 0, 0, 0);
    send_dates(1, 1, 2024, 1, 1, 2023);
    send_dates(15, 6, 1969, 15, 6, 9999);
  endtask

  // Limit of zero, one, the cap, and above the cap
  task automatic test_latest_year_extremes();
    set_latest_year(14'd0);
    send_dates(1, 1, 1, 1, 1, 1);
    set_latest_year(14'd1);
    send_dates(1, 1, 1, 31, 12, 1);
    send_dates(1, 1, 2, 1, 1, 1);
    set_latest_year(14'd9999);
    send_dates(1, 1, 1, 31, 12, 9999);
    send_dates(31, 12, 9999, 1, 1, 1);
    send_dates(29, 2, 9996, 1, 3, 9900);
    set_latest_year(14'h3FFF);
    send_dates(31, 12, 9999, 1, 1, 10000);
    send_dates(1, 1, 9999, 1, 1, 9998);
    send_dates(1, 1, 16383, 1, 1, 16383);
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, stall_pct,
                                  input logic [YearW-1:0] latest);
    set_latest_year(latest);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RandomPerPhase) send_pair(random_pair());
  endtask

  task automatic test_idle_phases();
    run_random_phase(0, 0, LatestYearRst);
    run_random_phase(65, 0, 14'd9999);
    run_random_phase(0, 65, YearW'($urandom_range(9999, 1)));
    run_random_phase(14, 14, 14'd400);
  endtask

  // Receiver holds off while the sender keeps offering: pipeline fills
  // and s_axis_tready must drop without losing a transaction
  task automatic test_backpressure();
    set_latest_year(14'd9999);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        recv_hold <= 1'b0;
      end
      repeat (HoldItems) send_pair(random_pair());
    join
  endtask

  // ---------------------------------------------------------------------
  // Result side: check each transaction against the oldest prediction
  // ---------------------------------------------------------------------
  initial begin : result_checker
    span_t want;
    span_t got;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.valid = m_axis_tuser;
        got.days  = m_axis_tdata[OrdW-1:0];
        if (pending_spans.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result transaction: valid %0d days %0d",
                   $time, got.valid, got.days);
        end else begin
          want = pending_spans.pop_front();
          if (got.valid !== want.valid) begin
            error_count++;
            $display("%0t: dates_valid mismatch: expected %0d, actual %0d",
                     $time, want.valid, got.valid);
          end
          if (got.days !== want.days) begin
            error_count++;
            $display("%0t: day_difference mismatch: expected %0d, actual %0d",
                     $time, want.days, got.days);
          end
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends the run when no transaction moves on either side for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, StallLimit, pending_spans.size());
    $display("calendar_date_difference_test failed");
    $finish;
  end

  // Test sequence
  initial begin : test_sequence
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_dates();
    test_latest_year_extremes();
    test_idle_phases();
    test_backpressure();

    s_axis_tvalid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0)
      $display("calendar_date_difference_test passed");
    else
      $display("calendar_date_difference_test failed");
    $finish;
  end

endmodule
